>>> rtl/core/dlg_pkg.sv
`default_nettype none
package dlg_pkg;

  // Field widths
  localparam int unsigned CoordW = 24;
  localparam int unsigned DashW  = 23;
  localparam logic [DashW-1:0] DashReset = 23'd1280;

  // Default dash limit per segment
  localparam int unsigned MaxDashesDef = 32;

  // Iteration counts of the sequential units
  localparam int unsigned SqrtIters = 25;
  localparam int unsigned CntIters  = 6;
  localparam int unsigned DivIters  = 31;
  localparam int unsigned IterW     = 5;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     path_start;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     dash_end;
    logic                     last;
  } out_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_CNT_INIT,
    OP_CNT_STEP,
    OP_MUL_X,
    OP_MUL_Y,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_INIT,
    OP_EMIT
  } dlg_op_e;

  typedef struct packed {
    dlg_op_e op;
  } cmd_t;

  typedef struct packed {
    logic seg_ok;
    logic len_zero;
    logic cnt_zero;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/dashed_line_generator.sv
// A path start point, or the first point, is only stored. A segment point runs the
// 25-step square root, the dash count and the 31-step step dividers, then emits 2n
// vertices, one per cycle while the receiver does not stall (none if the length or
// the dash count is zero). No new point is taken until its last vertex is emitted.
// Reset (rst_ni low, asynchronous): dash length 1280, no point stored, output empty.
`default_nettype none
module dashed_line_generator import dlg_pkg::*; #(
  parameter int unsigned MaxDashes = MaxDashesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DashW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Take register writes in every cycle
  assign cfg_ready_o = 1'b1;

  dlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlg_dp #(
    .MaxDashes (MaxDashes)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/dlg_ctrl.sv
`default_nettype none
module dlg_ctrl import dlg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SQX      = 4'd1;
  localparam logic [3:0] S_SQY      = 4'd2;
  localparam logic [3:0] S_SQINIT   = 4'd3;
  localparam logic [3:0] S_SQRT     = 4'd4;
  localparam logic [3:0] S_CNTINIT  = 4'd5;
  localparam logic [3:0] S_CNT      = 4'd6;
  localparam logic [3:0] S_MULX     = 4'd7;
  localparam logic [3:0] S_MULY     = 4'd8;
  localparam logic [3:0] S_DIVINIT  = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_EMITINIT = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Sequence the datapath through one segment
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SQX;
        end
      end
      S_SQX: begin
        if (!sts_i.seg_ok) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_SQ_X;
          state_d  = S_SQY;
        end
      end
      S_SQY: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_SQINIT;
      end
      S_SQINIT: begin
        cmd_o.op = OP_SQRT_INIT;
        iter_d   = IterW'(SqrtIters - 1);
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_CNTINIT;
      end
      S_CNTINIT: begin
        if (sts_i.len_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_CNT_INIT;
          iter_d   = IterW'(CntIters - 1);
          state_d  = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.op = OP_CNT_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_MULX;
      end
      S_MULX: begin
        if (sts_i.cnt_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_MUL_X;
          state_d  = S_MULY;
        end
      end
      S_MULY: begin
        cmd_o.op = OP_MUL_Y;
        state_d  = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd_o.op = OP_DIV_INIT;
        iter_d   = IterW'(DivIters - 1);
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        iter_d   = iter_q - 1'b1;
        if (iter_q == '0) state_d = S_EMITINIT;
      end
      S_EMITINIT: begin
        cmd_o.op = OP_EMIT_INIT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (sts_i.out_free && sts_i.emit_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dlg_dp.sv
`default_nettype none
module dlg_dp import dlg_pkg::*; #(
  parameter int unsigned MaxDashes = MaxDashesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_t              in_data_i,
  input  logic             cfg_valid_i,
  input  logic [DashW-1:0] cfg_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output out_t             out_data_o
);

  localparam int unsigned NW = $clog2(MaxDashes + 1);
  localparam int unsigned VW = NW + 1;

  // Stored path state and register
  logic [DashW-1:0]  dash_q;
  logic [CoordW-1:0] prev_x_q, prev_y_q;
  logic              have_prev_q;
  logic              seg_q;

  // Segment operands
  logic              neg_x_q, neg_y_q;
  logic [CoordW-1:0] ax_q, ay_q;
  logic [31:0]       acc_x_q, acc_y_q;

  // Shared multiplier and its hold register
  logic [23:0] mul_a, mul_b;
  logic [47:0] prod_q, hold_q;

  // Square root unit
  logic [49:0] rad_q;
  logic [26:0] srem_q;
  logic [24:0] root_q;
  logic [48:0] sum_w;
  logic [28:0] srem_sh, strial;

  // Dash count unit
  logic        sat_q;
  logic [24:0] crem_q;
  logic [29:0] cdiv_q;
  logic [5:0]  cq_q;
  logic [5:0]  dashes_w;
  logic [NW-1:0] n_w;

  // Step dividers, x and y in parallel
  logic [24:0] rem_x_q, rem_y_q;
  logic [30:0] bits_x_q, bits_y_q;
  logic [30:0] q_x_q, q_y_q;
  logic [25:0] tr_x, tr_y, len_ext;

  // Vertex emission
  logic [31:0]   step_x_q, step_y_q;
  logic [VW-1:0] vidx_q, last_idx_q;
  out_t          out_q;
  logic          out_valid_q;
  logic          out_free;

  logic [24:0] dx_w, dy_w, adx_w, ady_w;

  // Differences against the stored point
  always_comb begin
    dx_w  = {in_data_i.point_x[CoordW-1], in_data_i.point_x} - {prev_x_q[CoordW-1], prev_x_q};
    dy_w  = {in_data_i.point_y[CoordW-1], in_data_i.point_y} - {prev_y_q[CoordW-1], prev_y_q};
    adx_w = dx_w[24] ? (~dx_w + 25'd1) : dx_w;
    ady_w = dy_w[24] ? (~dy_w + 25'd1) : dy_w;
  end

  // Select multiplier operands
  always_comb begin
    case (cmd_i.op)
      OP_SQ_X: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      OP_SQ_Y: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      OP_MUL_X: begin
        mul_a = ax_q;
        mul_b = {1'b0, dash_q};
      end
      default: begin
        mul_a = ay_q;
        mul_b = {1'b0, dash_q};
      end
    endcase
  end

  assign sum_w   = {1'b0, hold_q} + {1'b0, prod_q};
  assign srem_sh = {srem_q, rad_q[49:48]};
  assign strial  = {2'b00, root_q, 2'b01};

  assign len_ext = {1'b0, root_q};
  assign tr_x    = {rem_x_q, bits_x_q[30]};
  assign tr_y    = {rem_y_q, bits_y_q[30]};

  // Clamp the dash count
  always_comb begin
    dashes_w = sat_q ? 6'd63 : cq_q;
    if ({1'b0, dashes_w} > 7'(MaxDashes)) n_w = NW'(MaxDashes);
    else                                  n_w = NW'(dashes_w);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.seg_ok    = seg_q && (dash_q != '0);
  assign sts_o.len_zero  = (root_q == '0);
  assign sts_o.cnt_zero  = (dashes_w == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_last = (vidx_q == last_idx_q);

  // Control state: register, stored point, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_q      <= DashReset;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      seg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) dash_q <= cfg_data_i;
      if (cmd_i.op == OP_LOAD) begin
        seg_q       <= have_prev_q && !in_data_i.path_start;
        prev_x_q    <= in_data_i.point_x;
        prev_y_q    <= in_data_i.point_y;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.op == OP_EMIT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)               out_valid_q <= 1'b0;
    end
  end

  // Payload datapath
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        neg_x_q <= dx_w[24];
        neg_y_q <= dy_w[24];
        ax_q    <= adx_w[CoordW-1:0];
        ay_q    <= ady_w[CoordW-1:0];
        acc_x_q <= {prev_x_q, 8'h00};
        acc_y_q <= {prev_y_q, 8'h00};
      end
      OP_SQ_X, OP_MUL_X: begin
        prod_q <= mul_a * mul_b;
      end
      OP_SQ_Y, OP_MUL_Y: begin
        prod_q <= mul_a * mul_b;
        hold_q <= prod_q;
      end
      OP_SQRT_INIT: begin
        rad_q  <= {1'b0, sum_w};
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT_STEP: begin
        rad_q <= {rad_q[47:0], 2'b00};
        if (srem_sh >= strial) begin
          srem_q <= 27'(srem_sh - strial);
          root_q <= {root_q[23:0], 1'b1};
        end else begin
          srem_q <= srem_sh[26:0];
          root_q <= {root_q[23:0], 1'b0};
        end
      end
      OP_CNT_INIT: begin
        sat_q  <= ({5'b0, root_q} >= {dash_q, 7'b0});
        crem_q <= root_q;
        cdiv_q <= {1'b0, dash_q, 6'b0};
        cq_q   <= '0;
      end
      OP_CNT_STEP: begin
        cdiv_q <= {1'b0, cdiv_q[29:1]};
        if ({5'b0, crem_q} >= cdiv_q) begin
          crem_q <= crem_q - cdiv_q[24:0];
          cq_q   <= {cq_q[4:0], 1'b1};
        end else begin
          cq_q   <= {cq_q[4:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        rem_x_q  <= {1'b0, hold_q[46:23]};
        rem_y_q  <= {1'b0, prod_q[46:23]};
        bits_x_q <= {hold_q[22:0], 8'h00};
        bits_y_q <= {prod_q[22:0], 8'h00};
        q_x_q    <= '0;
        q_y_q    <= '0;
      end
      OP_DIV_STEP: begin
        bits_x_q <= {bits_x_q[29:0], 1'b0};
        bits_y_q <= {bits_y_q[29:0], 1'b0};
        if (tr_x >= len_ext) begin
          rem_x_q <= 25'(tr_x - len_ext);
          q_x_q   <= {q_x_q[29:0], 1'b1};
        end else begin
          rem_x_q <= tr_x[24:0];
          q_x_q   <= {q_x_q[29:0], 1'b0};
        end
        if (tr_y >= len_ext) begin
          rem_y_q <= 25'(tr_y - len_ext);
          q_y_q   <= {q_y_q[29:0], 1'b1};
        end else begin
          rem_y_q <= tr_y[24:0];
          q_y_q   <= {q_y_q[29:0], 1'b0};
        end
      end
      OP_EMIT_INIT: begin
        step_x_q   <= neg_x_q ? (32'd0 - {1'b0, q_x_q}) : {1'b0, q_x_q};
        step_y_q   <= neg_y_q ? (32'd0 - {1'b0, q_y_q}) : {1'b0, q_y_q};
        vidx_q     <= '0;
        last_idx_q <= {n_w, 1'b0} - 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_q.vertex_x <= acc_x_q[31:8];
          out_q.vertex_y <= acc_y_q[31:8];
          out_q.dash_end <= vidx_q[0];
          out_q.last     <= (vidx_q == last_idx_q);
          acc_x_q        <= acc_x_q + step_x_q;
          acc_y_q        <= acc_y_q + step_y_q;
          vidx_q         <= vidx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> dv/tb_dashed_line_generator.sv
`timescale 1ns / 1ps

// Tracks the dash vertices each accepted point must produce and matches
// them against the vertices the block emits.
class dash_vertex_tracker;
  logic [dlg_pkg::DashW-1:0]         dash_len;
  logic signed [dlg_pkg::CoordW-1:0] prev_x;
  logic signed [dlg_pkg::CoordW-1:0] prev_y;
  bit                                have_prev;
  dlg_pkg::out_t                     vertices_due[$];
  int                                errors;

  function new();
    dash_len  = dlg_pkg::DashReset;
    prev_x    = '0;
    prev_y    = '0;
    have_prev = 1'b0;
    errors    = 0;
  endfunction

  function void set_dash(logic [dlg_pkg::DashW-1:0] value);
    dash_len = value;
  endfunction

  // Exact integer square root, digit by digit
  function longint unsigned root_of(longint unsigned value);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned probe;
    rem   = value;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Work out the vertices caused by one accepted point, then store the point
  function void take_point(dlg_pkg::in_t pt);
    longint          ox;
    longint          oy;
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned seg_len;
    longint unsigned dl;
    longint unsigned dashes;
    longint unsigned qx;
    longint unsigned qy;
    logic [63:0]     step_x;
    logic [63:0]     step_y;
    logic [63:0]     acc_x;
    logic [63:0]     acc_y;
    int              nv;
    dlg_pkg::out_t   vtx;
    bit              segment;

    ox      = longint'($signed(prev_x));
    oy      = longint'($signed(prev_y));
    segment = have_prev && !pt.path_start;
    prev_x    = pt.point_x;
    prev_y    = pt.point_y;
    have_prev = 1'b1;
    dl        = longint'(dash_len);

    if (!segment || dl == 0) return;

    dx = longint'($signed(pt.point_x)) - ox;
    dy = longint'($signed(pt.point_y)) - oy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    seg_len = root_of(ax * ax + ay * ay);
    if (seg_len == 0) return;

    dashes = (seg_len / dl) / 2;
    if (dashes > dlg_pkg::MaxDashesDef) dashes = dlg_pkg::MaxDashesDef;
    if (dashes == 0) return;

    // Step of one dash length in units of 2^-8, truncated toward zero
    qx     = (ax * dl * 256) / seg_len;
    qy     = (ay * dl * 256) / seg_len;
    step_x = (dx < 0) ? (64'd0 - qx) : qx;
    step_y = (dy < 0) ? (64'd0 - qy) : qy;
    acc_x  = 64'(ox) << 8;
    acc_y  = 64'(oy) << 8;
    nv     = int'(dashes) * 2;

    for (int k = 0; k < nv; k++) begin
      vtx.vertex_x = acc_x[31:8];
      vtx.vertex_y = acc_y[31:8];
      vtx.dash_end = k[0];
      vtx.last     = (k == nv - 1);
      vertices_due.push_back(vtx);
      acc_x = acc_x + step_x;
      acc_y = acc_y + step_y;
    end
  endfunction

  // Compare one emitted vertex with the oldest one due
  function void match_vertex(dlg_pkg::out_t got);
    dlg_pkg::out_t want;
    if (vertices_due.size() == 0) begin
      $error("vertex with none due: x %0d y %0d dash_end %0b last %0b",
             $signed(got.vertex_x), $signed(got.vertex_y), got.dash_end, got.last);
      errors++;
      return;
    end
    want = vertices_due.pop_front();
    if (got.vertex_x !== want.vertex_x) begin
      $error("vertex_x: expected %0d, actual %0d",
             $signed(want.vertex_x), $signed(got.vertex_x));
      errors++;
    end
    if (got.vertex_y !== want.vertex_y) begin
      $error("vertex_y: expected %0d, actual %0d",
             $signed(want.vertex_y), $signed(got.vertex_y));
      errors++;
    end
    if (got.dash_end !== want.dash_end) begin
      $error("dash_end: expected %0b, actual %0b", want.dash_end, got.dash_end);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_dashed_line_generator;
  import dlg_pkg::*;

  localparam int unsigned IdleLimit     = 4000;
  localparam int unsigned SettleCycles  = 200;
  localparam int unsigned SinkHoldCycles = 600;
  localparam int unsigned PhaseItems    = 74;
  localparam int unsigned RandPhases    = 5;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [DashW-1:0] cfg_data_i  = '0;

  dash_vertex_tracker tracker;
  bit                 sink_hold = 1'b0;
  int                 burst_left = 0;

  dashed_line_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic in_t mk_point(longint x, longint y, bit start);
    in_t pt;
    pt.point_x    = CoordW'(x);
    pt.point_y    = CoordW'(y);
    pt.path_start = start;
    return pt;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Random next point: mostly segments sized to the dash length, plus noise
  function automatic in_t next_point();
    int              r;
    longint unsigned dl;
    longint unsigned seg_len;
    longint unsigned ax;
    longint unsigned ay;
    longint          dx;
    longint          dy;
    longint          px;
    longint          py;

    r  = $urandom_range(0, 99);
    dl = (tracker.dash_len == 0) ? 64'd1280 : longint'(tracker.dash_len);
    px = longint'($signed(tracker.prev_x));
    py = longint'($signed(tracker.prev_y));
    if (r < 8) return mk_point($signed($urandom()), $signed($urandom()), 1'b1);
    if (r < 20) return mk_point($signed($urandom()), $signed($urandom()), 1'b0);
    if (r < 25) return mk_point(px, py, 1'b0);
    if (r < 35) begin
      seg_len = $urandom_range(0, 32'(2 * dl - 1));
    end else begin
      seg_len = dl * 2 * $urandom_range(1, 36) + $urandom_range(0, 32'(2 * dl - 1));
    end
    if (seg_len > 8000000) seg_len = 8000000;
    ax = $urandom_range(0, 32'(seg_len));
    ay = tracker.root_of(seg_len * seg_len - ax * ax);
    dx = $urandom_range(0, 1) ? -longint'(ax) : longint'(ax);
    dy = $urandom_range(0, 1) ? -longint'(ay) : longint'(ay);
    return mk_point(px + dx, py + dy, 1'b0);
  endfunction

  // Offer one point after a random gap, or none in a burst, and hold it until the request is taken
  task automatic send_point(in_t pt);
    int gap;
    gap = (burst_left > 0) ? 0 : pick_gap();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_point(pt);
  endtask

  // Drop the input, wait for every vertex due, then let the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.vertices_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_dash(logic [DashW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_dash(value);
  endtask

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    forever begin
      if (sink_hold) begin
        out_stall_i <= 1'b1;
        repeat (SinkHoldCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if ($urandom_range(0, 99) < 40) begin
        out_stall_i <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
        else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // Check every vertex taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_vertex(out_data_o);
  end

  // End the run when no request of any kind has been taken for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [DashW-1:0] dash;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset dash length: orphan point, zero length, short, saturating segments
    send_point(mk_point(100, 200, 1'b0));
    send_point(mk_point(100, 200, 1'b0));
    send_point(mk_point(2100, 200, 1'b0));
    send_point(mk_point(2100, 2760, 1'b0));
    send_point(mk_point(-8388608, -8388608, 1'b0));
    send_point(mk_point(8388607, 8388607, 1'b0));
    send_point(mk_point(8388607, -8388608, 1'b1));
    send_point(mk_point(-8388608, 8388607, 1'b0));
    send_point(mk_point(0, 0, 1'b0));
    settle();

    // Shortest dash
    write_dash(DashW'(1));
    send_point(mk_point(5, 0, 1'b0));
    send_point(mk_point(-300, 77, 1'b0));
    settle();

    // Longest dash across the full coordinate range
    write_dash({DashW{1'b1}});
    send_point(mk_point(-8388608, -8388608, 1'b1));
    send_point(mk_point(8388607, 8388607, 1'b0));
    send_point(mk_point(8388607, -8388608, 1'b0));
    settle();

    // Zero dash length emits nothing
    write_dash('0);
    send_point(mk_point(0, 0, 1'b0));
    send_point(mk_point(1000, 1000, 1'b0));
    settle();

    // Random phases, each with its own dash length
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: dash = DashW'($urandom_range(1, 4));
        1: dash = DashW'($urandom_range(200, 2000));
        2: dash = DashW'($urandom_range(2000, 40000));
        3: dash = DashW'($urandom_range(40000, 1500000));
        default: dash = DashW'($urandom_range(5, 200));
      endcase
      write_dash(dash);
      for (int i = 0; i < PhaseItems; i++) begin
        // Hold the receiver off while points keep coming
        if (ph == 1 && i == 5) begin
          sink_hold  = 1'b1;
          burst_left = 20;
        end
        // Pause the sender until every vertex due has arrived
        if (ph == 2 && i == 30) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (tracker.vertices_due.size() != 0);
        end
        send_point(next_point());
      end
      settle();
    end

    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
